// File: design/sbsc_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_pkg: shared definitions for the baseline stability calibrator
// Widths, codes, lane command and result structs, and the baseline reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsc_pkg;

  // sizing
  localparam int unsigned NCH        = 3;
  localparam int unsigned WINDOW_MAX = 256;
  localparam int unsigned AVG_COUNT  = 32;
  localparam int unsigned AVG_SHIFT  = 5;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned RD_W     = 11;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CNT_W    = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam int unsigned ACC_W    = SAMPLE_W + CNT_W + 1;
  localparam int unsigned PTR_W    = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LCMP_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int unsigned SUM_W    = RD_W + PTR_W;
  localparam int unsigned STEP_W   = $clog2(SUM_W + 1);
  localparam int unsigned RD_MAX   = (1 << RD_W) - 1;

  // stream words
  localparam int unsigned IN_DATA_W  = ((NCH * SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = NCH + 1 + NCH * RD_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // APB
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index (paddr bit 2)
  localparam logic REG_WINDOW_LEN   = 1'b0;
  localparam logic REG_STABLE_DELTA = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST   = 8'd16;
  localparam logic [CFG_W-1:0] STABLE_DELTA_RST = 8'd8;

  // input word kind
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FIN
  } state_e;

  // control from the sequencer to every lane
  typedef struct packed {
    logic              accum;      // add the sample to the accumulator
    logic              take;       // this sample closes a reading
    logic              clear;      // restart
    logic              update;     // window RAM data is back: new sum, write entry
    logic              old_valid;  // window entry holds a written value
    logic              step;       // one divider iteration
    logic [PTR_W-1:0]  addr;       // window entry
    logic [LEN_W-1:0]  len;        // effective window length
    logic [CFG_W-1:0]  delta;      // stability threshold
  } lane_cmd_t;

  typedef struct packed {
    logic            stable;
    logic [RD_W-1:0] mean;
  } lane_res_t;

  typedef struct packed {
    logic [NCH-1:0]           flags;
    logic                     done;
    logic [NCH-1:0][RD_W-1:0] base;
  } merge_st_t;

  function automatic logic [RD_W-1:0] base_reset(input int unsigned ch);
    logic [RD_W-1:0] v;
    case (ch)
      0:       v = RD_W'(120);
      1:       v = RD_W'(300);
      default: v = RD_W'(710);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/sbsc_ram.sv
// ----------------------------------------------------------------------------
// sbsc_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/sbsc_lane.sv
// ----------------------------------------------------------------------------
// sbsc_lane: one sensor channel
// 32-sample averager, ring window with running sum, serial mean divider and
// stability compare.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsc_lane (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire sbsc_pkg::lane_cmd_t              cmd_i,
  input  wire logic signed [sbsc_pkg::SAMPLE_W-1:0] sample_i,
  output sbsc_pkg::lane_res_t                   res_o
);
  import sbsc_pkg::*;

  logic signed [ACC_W-1:0] acc_q, acc_d, acc_sum;
  logic [ACC_W-1:0]        acc_sh;
  logic [RD_W-1:0]         avg;
  logic [RD_W-1:0]         rd_q;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [SUM_W-1:0]        quo_q, quo_d;
  logic [LEN_W-1:0]        rem_q, rem_d;
  logic [LEN_W:0]          trial;
  logic                    fits;
  logic [RD_W-1:0]         ram_rdata;
  logic [RD_W-1:0]         old;
  logic [SUM_W-1:0]        diff;

  // accumulator and averaged reading (negative clamps to zero)
  assign acc_sum = acc_q + {{(ACC_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign acc_sh  = ACC_W'(acc_sum) >> AVG_SHIFT;

  always_comb begin
    if (acc_sum[ACC_W-1]) begin
      avg = '0;
    end else if (acc_sh > ACC_W'(RD_MAX)) begin
      avg = RD_W'(RD_MAX);
    end else begin
      avg = acc_sh[RD_W-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.clear || cmd_i.take) begin
      acc_d = '0;
    end else if (cmd_i.accum) begin
      acc_d = acc_sum;
    end
  end

  // window entries of this channel
  sbsc_ram #(
    .WIDTH (RD_W),
    .DEPTH (WINDOW_MAX)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (cmd_i.addr),
    .wdata_i (rd_q),
    .re_i    (cmd_i.take),
    .raddr_i (cmd_i.addr),
    .rdata_o (ram_rdata)
  );

  // running sum: drop the replaced entry, add the new reading
  assign old = cmd_i.old_valid ? ram_rdata : '0;

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.clear) begin
      sum_d = '0;
    end else if (cmd_i.update) begin
      sum_d = sum_q - SUM_W'(old) + SUM_W'(rd_q);
    end
  end

  // restoring divider, one quotient bit per step
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= (LEN_W + 1)'(cmd_i.len);

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.update) begin
      quo_d = sum_d;
      rem_d = '0;
    end else if (cmd_i.step) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? LEN_W'(trial - (LEN_W + 1)'(cmd_i.len)) : trial[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sum_q <= '0;
    end else begin
      acc_q <= acc_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_q <= avg;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // stability: |mean - reading| < delta
  assign diff = (quo_q > SUM_W'(rd_q)) ? (quo_q - SUM_W'(rd_q)) : (SUM_W'(rd_q) - quo_q);

  assign res_o.stable = diff < SUM_W'(cmd_i.delta);
  assign res_o.mean   = quo_q[RD_W-1:0];

endmodule

`default_nettype wire

// File: design/sbsc_merge.sv
// ----------------------------------------------------------------------------
// sbsc_merge: combines the lane results
// Holds the stable flags, the done flag and the three baselines.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsc_merge (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             clear_i,
  input  wire logic                             load_i,
  input  wire sbsc_pkg::lane_res_t [sbsc_pkg::NCH-1:0] res_i,
  output sbsc_pkg::merge_st_t                   st_o
);
  import sbsc_pkg::*;

  logic [NCH-1:0]           flags_q, flags_d;
  logic                     done_q, done_d;
  logic [NCH-1:0][RD_W-1:0] base_q, base_d;
  logic [NCH-1:0]           stab;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      stab[c] = res_i[c].stable;
    end
  end

  always_comb begin
    flags_d = flags_q;
    done_d  = done_q;
    base_d  = base_q;
    if (clear_i) begin
      flags_d = '0;
      done_d  = 1'b0;
    end else if (load_i) begin
      flags_d = stab;
      // all channels settled: the window means become the baselines
      if (&stab) begin
        done_d = 1'b1;
        for (int c = 0; c < NCH; c++) begin
          base_d[c] = res_i[c].mean;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      done_q  <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        base_q[c] <= base_reset(c);
      end
    end else begin
      flags_q <= flags_d;
      done_q  <= done_d;
      base_q  <= base_d;
    end
  end

  assign st_o.flags = flags_q;
  assign st_o.done  = done_q;
  assign st_o.base  = base_q;

endmodule

`default_nettype wire

// File: design/sensor_baseline_stability_calibrator_core.sv
// ----------------------------------------------------------------------------
// sensor_baseline_stability_calibrator_core: gas sensor baseline calibrator
// Three channel lanes, a sequencer, a merge stage and the APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per ADC sample triple; tuser = 1 asks for a
//   restart that clears the windows and the done flag (baselines are kept).
//   m_axis returns exactly one word per input word: the stable flags, the
//   done flag and the three baselines; tuser marks a fresh averaged reading.
//   Window length and stability threshold are written over APB while idle.
// Timing:
//   A plain sample, a restart or a sample after done is handled without
//   leaving ST_IDLE; its word passes the pending flag and then the output
//   register on its way to m_axis. Every 32nd sample closes a reading: the
//   window RAM read (ST_READ), the bit-serial mean divider (ST_DIV, one bit
//   per step, 19-bit window sum) and the merge (ST_FIN), then the pending
//   flag and the output register; the input is held off meanwhile.
// Reset and stall:
//   Reset restores the registers to length 16 and threshold 8, baselines to
//   120, 300 and 710, and clears the per-row valid bits of the windows at
//   once, so no clearing pass is needed. A stalled m_axis keeps its word in
//   the output register; one more finished word may wait behind it, after
//   which s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_baseline_stability_calibrator_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input words
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: sample_nh3[11:0], sample_co[23:12], sample_no2[35:24], zero fill
  input  wire logic [sbsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: mode[0]
  input  wire logic [0:0]                         s_axis_tuser,
  // result words
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: nh3_stable[0], co_stable[1], no2_stable[2], done_res[3],
  //        base_nh3[14:4], base_co[25:15], base_no2[36:26], zero fill
  output logic [sbsc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // tuser: reading_ready[0]
  output logic [0:0]                              m_axis_tuser,
  // APB configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sbsc_pkg::APB_AW-1:0]        paddr,
  input  wire logic [sbsc_pkg::APB_DW-1:0]        pwdata,
  output logic [sbsc_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);
  import sbsc_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  win_len_q, delta_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [PTR_W-1:0]  ptr_use, ptr_use_q;
  logic [LEN_W-1:0]  len_eff, ptr_inc;
  logic [LCMP_W-1:0] len_wide;
  logic [STEP_W-1:0] step_q, step_d;
  logic              row_vld_q [WINDOW_MAX];

  logic              in_fire, is_restart, is_live, is_reading;
  logic              pend_q, pend_d, rdy_q, rdy_d;
  logic              out_free;
  logic              out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic              out_user_q;

  lane_cmd_t                 cmd;
  lane_res_t [NCH-1:0]       lane_res;
  logic signed [SAMPLE_W-1:0] samples [NCH];
  merge_st_t                 mst;
  logic                      merge_clear, merge_load;
  logic                      apb_wr;

  // ---------------- APB registers ----------------
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WINDOW_LEN_RST;
      delta_q   <= STABLE_DELTA_RST;
    end else if (apb_wr) begin
      case (paddr[2])
        REG_WINDOW_LEN:   win_len_q <= pwdata[CFG_W-1:0];
        REG_STABLE_DELTA: delta_q   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_LEN:   prdata = APB_DW'(win_len_q);
      REG_STABLE_DELTA: prdata = APB_DW'(delta_q);
      default:          prdata = '0;
    endcase
  end

  // effective length: zero counts as one, clipped to the window depth
  always_comb begin
    len_wide = LCMP_W'(win_len_q);
    if (len_wide == '0) begin
      len_wide = LCMP_W'(1);
    end else if (len_wide > LCMP_W'(WINDOW_MAX)) begin
      len_wide = LCMP_W'(WINDOW_MAX);
    end
    len_eff = len_wide[LEN_W-1:0];
  end

  // pointer beyond a shortened window wraps to the first entry
  assign ptr_use = (LEN_W'(ptr_q) >= len_eff) ? '0 : ptr_q;
  assign ptr_inc = LEN_W'(ptr_use_q) + LEN_W'(1);

  // ---------------- input word decode ----------------
  assign s_axis_tready = (state_q == ST_IDLE) && (!pend_q || out_free);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_restart    = s_axis_tuser[0] == MODE_RESTART;
  assign is_live       = !is_restart && !mst.done;
  assign is_reading    = is_live && (count_q == CNT_W'(AVG_COUNT - 1));

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      samples[c] = s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && is_reading) state_d = ST_READ;
      ST_READ: state_d = ST_DIV;
      ST_DIV:  if (step_q == STEP_W'(SUM_W - 1)) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    cmd           = '0;
    cmd.len       = len_eff;
    cmd.delta     = delta_q;
    cmd.addr      = ptr_use_q;
    cmd.old_valid = row_vld_q[ptr_use_q];
    merge_clear   = 1'b0;
    merge_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd.addr    = ptr_use;
        cmd.accum   = in_fire && is_live;
        cmd.take    = in_fire && is_reading;
        cmd.clear   = in_fire && is_restart;
        merge_clear = in_fire && is_restart;
      end
      ST_READ: cmd.update = 1'b1;
      ST_DIV:  cmd.step   = 1'b1;
      ST_FIN:  merge_load = 1'b1;
      default: ;
    endcase
  end

  // ---------------- counters, pointer, pending result ----------------
  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    step_d  = step_q;
    pend_d  = pend_q;
    rdy_d   = rdy_q;
    if (pend_q && out_free) begin
      pend_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_restart) begin
            count_d = '0;
            ptr_d   = '0;
          end else if (is_reading) begin
            count_d = '0;
          end else if (is_live) begin
            count_d = count_q + CNT_W'(1);
          end
          if (!is_reading) begin
            pend_d = 1'b1;
            rdy_d  = 1'b0;
          end
        end
        step_d = '0;
      end
      ST_READ: begin
        ptr_d = (ptr_inc >= len_eff) ? '0 : ptr_inc[PTR_W-1:0];
      end
      ST_DIV:  step_d = step_q + STEP_W'(1);
      ST_FIN: begin
        pend_d = 1'b1;
        rdy_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      step_q  <= '0;
      pend_q  <= 1'b0;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      step_q  <= step_d;
      pend_q  <= pend_d;
      rdy_q   <= rdy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.take) begin
      ptr_use_q <= ptr_use;
    end
  end

  // row valid bits: an unwritten window row reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < WINDOW_MAX; r++) begin
        row_vld_q[r] <= 1'b0;
      end
    end else if (cmd.clear) begin
      for (int r = 0; r < WINDOW_MAX; r++) begin
        row_vld_q[r] <= 1'b0;
      end
    end else if (cmd.update) begin
      row_vld_q[ptr_use_q] <= 1'b1;
    end
  end

  // ---------------- lanes and merge ----------------
  for (genvar c = 0; c < NCH; c++) begin : g_lane
    sbsc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .sample_i (samples[c]),
      .res_o    (lane_res[c])
    );
  end

  sbsc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (merge_clear),
    .load_i  (merge_load),
    .res_i   (lane_res),
    .st_o    (mst)
  );

  // ---------------- output register ----------------
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_data_q <= OUT_DATA_W'({mst.base, mst.done, mst.flags});
      out_user_q <= rdy_q;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

  // ---------------- assertions ----------------
  a_fin_posts_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> pend_q && rdy_q)
    else $error("merge cycle did not post a reading word");

  a_read_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_DIV && step_q == '0)
    else $error("divider not started after window read");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mst.done && !(in_fire && is_restart) |=> mst.done)
    else $error("done flag dropped without restart");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_free |-> !s_axis_tready)
    else $error("input taken while a word is still waiting");

endmodule

`default_nettype wire

// File: tb/tb_sensor_baseline_stability_calibrator_core.sv
// ----------------------------------------------------------------------------
// tb_sensor_baseline_stability_calibrator_core: calibrator core testbench
// Drives sample triples and restarts over the input stream and random idle
// gaps on both stream sides. Window length and threshold change over APB
// between phases. A scoreboard predicts every result word and compares it
// field by field.
// ----------------------------------------------------------------------------

module tb_sensor_baseline_stability_calibrator_core;
  import sbsc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NH3_BASE_RST = 120;
  localparam int unsigned CO_BASE_RST  = 300;
  localparam int unsigned NO2_BASE_RST = 710;

  // one result word, unpacked from the stream
  typedef struct packed {
    logic                     ready;
    logic [NCH-1:0]           flags;
    logic                     done;
    logic [NCH-1:0][RD_W-1:0] base;
  } calib_word_t;

  // --------------------------------------------------------------------------
  // scoreboard: calibrator predictor plus queue of expected words
  // --------------------------------------------------------------------------
  class calib_scoreboard;
    logic [CFG_W-1:0] win_len;
    logic [CFG_W-1:0] delta;
    int               acc[NCH];
    int unsigned      count;
    logic [RD_W-1:0]  win[NCH][WINDOW_MAX];
    int unsigned      sums[NCH];
    int unsigned      ptr;
    logic [NCH-1:0]   flags;
    logic [RD_W-1:0]  base[NCH];
    bit               done;
    calib_word_t      expected_words[$];
    int unsigned      errors;
    int unsigned      word_no;

    function new();
      win_len = WINDOW_LEN_RST;
      delta   = STABLE_DELTA_RST;
      errors  = 0;
      word_no = 0;
      base[0] = RD_W'(NH3_BASE_RST);
      base[1] = RD_W'(CO_BASE_RST);
      base[2] = RD_W'(NO2_BASE_RST);
      clear_run();
    endfunction

    function void clear_run();
      for (int c = 0; c < NCH; c++) begin
        acc[c]  = 0;
        sums[c] = 0;
        for (int i = 0; i < WINDOW_MAX; i++) win[c][i] = '0;
      end
      count = 0;
      ptr   = 0;
      flags = '0;
      done  = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_WINDOW_LEN) win_len = val;
      else delta = val;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // accepted input word: advance the model and queue its result
    function void note_word(logic mode, logic [NCH*SAMPLE_W-1:0] samples);
      calib_word_t                 w;
      logic signed [SAMPLE_W-1:0]  smp;
      logic [NCH-1:0]              nf;
      int unsigned                 len, rd, diff;
      int unsigned                 mean[NCH];
      w.ready = 1'b0;
      if (mode == MODE_RESTART) begin
        clear_run();
      end else if (!done) begin
        for (int c = 0; c < NCH; c++) begin
          smp = samples[c*SAMPLE_W +: SAMPLE_W];
          acc[c] += smp;
        end
        count++;
        if (count >= AVG_COUNT) begin
          len = (win_len == 0) ? 1 : win_len;
          if (len > WINDOW_MAX) len = WINDOW_MAX;
          if (ptr >= len) ptr = 0;
          nf = '0;
          for (int c = 0; c < NCH; c++) begin
            // floor average, negative clamps to zero
            rd = (acc[c] < 0) ? 0 : (acc[c] >>> AVG_SHIFT);
            if (rd > RD_MAX) rd = RD_MAX;
            sums[c] = sums[c] - win[c][ptr] + rd;
            win[c][ptr] = RD_W'(rd);
            mean[c] = sums[c] / len;
            diff = (mean[c] > rd) ? mean[c] - rd : rd - mean[c];
            if (diff < delta) nf[c] = 1'b1;
            acc[c] = 0;
          end
          count = 0;
          ptr = (ptr + 1 >= len) ? 0 : ptr + 1;
          flags = nf;
          w.ready = 1'b1;
          if (&nf) begin
            for (int c = 0; c < NCH; c++) base[c] = RD_W'(mean[c]);
            done = 1'b1;
          end
        end
      end
      w.flags = flags;
      w.done  = done;
      for (int c = 0; c < NCH; c++) w.base[c] = base[c];
      expected_words.push_back(w);
    endfunction

    // accepted result word: compare with the oldest expectation
    function void check_result(logic [0:0] tuser, logic [OUT_DATA_W-1:0] tdata);
      calib_word_t e, a;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result word tuser %b tdata %h", tuser, tdata));
        return;
      end
      e = expected_words.pop_front();
      a.ready = tuser[0];
      a.flags = tdata[NCH-1:0];
      a.done  = tdata[NCH];
      a.base  = tdata[NCH+1 +: NCH*RD_W];
      if (a.ready !== e.ready)
        report($sformatf("word %0d reading_ready exp %b act %b", word_no, e.ready, a.ready));
      if (a.flags !== e.flags)
        report($sformatf("word %0d stable flags exp %b act %b", word_no, e.flags, a.flags));
      if (a.done !== e.done)
        report($sformatf("word %0d done_res exp %b act %b", word_no, e.done, a.done));
      for (int c = 0; c < NCH; c++)
        if (a.base[c] !== e.base[c])
          report($sformatf("word %0d baseline %0d exp %0d act %0d",
                           word_no, c, e.base[c], a.base[c]));
      word_no++;
    endfunction

    function void close_out();
      if (expected_words.size() != 0)
        report($sformatf("%0d result words never arrived", expected_words.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  calib_scoreboard sb;
  bit              idle_on;
  int unsigned     quiet_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  sensor_baseline_stability_calibrator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // watchdog: cycles without any handshake
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL sensor_baseline_stability_calibrator_core");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // one input word; starts and ends just after a falling edge
  task automatic send_word(input logic mode, input logic [NCH*SAMPLE_W-1:0] samples);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(samples);
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(mode, samples);
    @(negedge clk_i);
  endtask

  // drain all expected words, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] data;
    data = $urandom();
    data[CFG_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_check(input logic idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== val)
      sb.report($sformatf("register %0d read exp %0d act %0d", idx, val, prdata[CFG_W-1:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] thr);
    apb_write(REG_WINDOW_LEN, len);
    apb_write(REG_STABLE_DELTA, thr);
    apb_check(REG_WINDOW_LEN, len);
    apb_check(REG_STABLE_DELTA, thr);
  endtask

  // channel level for one segment: negative, near zero, mid range or an extreme
  function automatic int draw_level();
    case ($urandom_range(0, 4))
      0:       return -int'($urandom_range(1, 2048));
      1:       return int'($urandom_range(0, 64));
      4:       return $urandom_range(0, 1) ? 2047 : -2048;
      default: return int'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic int unsigned draw_noise();
    case ($urandom_range(0, 7))
      0, 1:    return 0;
      5:       return 12;
      6:       return 60;
      7:       return 4096;
      default: return 3;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(int level, int unsigned amp);
    int v;
    if (amp >= 2048) return SAMPLE_W'($urandom());
    v = level + int'($urandom_range(0, 2 * amp)) - int'(amp);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return SAMPLE_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // result sink with random stalls
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] len_tbl[8] = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd255, 8'd6, 8'd1, 8'd16};
  logic [CFG_W-1:0] thr_tbl[8] = '{8'd8, 8'd4, 8'd255, 8'd0, 8'd8, 8'd30, 8'd1, 8'd8};

  initial begin : stimulus
    int unsigned                counted, phase, phase_items, seg_left, amp;
    int                         lvl[NCH];
    logic [CFG_W-1:0]           len, thr;
    logic [NCH*SAMPLE_W-1:0]    smp;
    logic                       mode;
    sb            = new();
    idle_on       = 1'b1;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_SAMPLE;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, bit patterns and restarts with junk data
    apb_check(REG_WINDOW_LEN, WINDOW_LEN_RST);
    apb_check(REG_STABLE_DELTA, STABLE_DELTA_RST);
    send_word(MODE_RESTART, '1);
    send_word(MODE_SAMPLE, {3{12'h7FF}});
    send_word(MODE_SAMPLE, {3{12'h800}});
    send_word(MODE_SAMPLE, '0);
    send_word(MODE_SAMPLE, '1);
    send_word(MODE_SAMPLE, {12'hAAA, 12'h555, 12'hAAA});
    send_word(MODE_SAMPLE, {12'h555, 12'hAAA, 12'h555});
    send_word(MODE_SAMPLE, {12'h800, 12'h7FF, 12'h000});
    send_word(MODE_SAMPLE, {12'h001, 12'hFFF, 12'h7FF});
    send_word(MODE_RESTART, {12'h7FF, 12'h800, 12'h555});
    send_word(MODE_SAMPLE, {12'h7FF, 12'h800, 12'h001});
    send_word(MODE_RESTART, '0);

    // random phases, each with its own register setting
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      wait_idle();
      if (phase < 8) begin
        len = len_tbl[phase];
        thr = thr_tbl[phase];
      end else begin
        len = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 255))
                                          : CFG_W'($urandom_range(0, 6));
        thr = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 255))
                                          : CFG_W'($urandom_range(1, 24));
      end
      set_config(len, thr);
      idle_on = ($urandom_range(0, 3) != 0);
      // a phase without restart keeps stale window contents
      if ($urandom_range(0, 3) != 0) send_word(MODE_RESTART, {NCH*SAMPLE_W{1'b0}} | $urandom());
      phase_items = $urandom_range(150, 280);
      seg_left = 0;
      amp = 0;
      while (phase_items != 0 && counted < RANDOM_ITEMS) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 160);
          amp = draw_noise();
          for (int c = 0; c < NCH; c++) lvl[c] = draw_level();
        end
        seg_left--;
        for (int c = 0; c < NCH; c++) smp[c*SAMPLE_W +: SAMPLE_W] = draw_sample(lvl[c], amp);
        if (sb.done) mode = ($urandom_range(0, 5) == 0) ? MODE_RESTART : MODE_SAMPLE;
        else mode = ($urandom_range(0, 39) == 0) ? MODE_RESTART : MODE_SAMPLE;
        // samples after done are ignored and do not count
        if (!(sb.done && mode == MODE_SAMPLE)) begin
          counted++;
          phase_items--;
        end
        send_word(mode, smp);
      end
      phase++;
    end

    // drain and settle
    wait_idle();
    sb.close_out();
    if (sb.errors == 0) begin
      $display("PASS sensor_baseline_stability_calibrator_core");
    end else begin
      $display("FAIL sensor_baseline_stability_calibrator_core");
    end
    $finish;
  end

endmodule

// File: sensor_baseline_stability_calibrator_core.f
design/sbsc_pkg.sv
design/sbsc_ram.sv
design/sbsc_lane.sv
design/sbsc_merge.sv
design/sensor_baseline_stability_calibrator_core.sv
tb/tb_sensor_baseline_stability_calibrator_core.sv
